### rtl/core/spnc_pkg.sv
// shared types and codes for the shortest path block with negative cycle detection
`default_nettype none
package spnc_pkg;
   localparam int NODE_W   = 6;
   localparam int COUNT_W  = 7;
   localparam int WEIGHT_W = 32;
   localparam int DIST_W   = 48;
   localparam int SUM_W    = ((DIST_W > WEIGHT_W) ? DIST_W : WEIGHT_W) + 1;
   localparam int EDGE_W   = 2 * NODE_W + WEIGHT_W;

   localparam logic [2:0] ADDR_NODE_COUNT  = 3'd0;
   localparam logic [2:0] ADDR_SOURCE_NODE = 3'd4;

   typedef enum logic [1:0] {
      CMD_LOAD  = 2'd0,
      CMD_RUN   = 2'd1,
      CMD_CLEAR = 2'd2,
      CMD_NONE  = 2'd3
   } command_type;

   typedef enum logic [1:0] {
      ST_FINITE      = 2'd0,
      ST_UNREACHABLE = 2'd1,
      ST_MINUS_INF   = 2'd2,
      ST_OVERFLOW    = 2'd3
   } status_type;

   typedef struct packed {
      logic [1:0]                 command;
      logic [NODE_W-1:0]          edge_from;
      logic [NODE_W-1:0]          edge_to;
      logic signed [WEIGHT_W-1:0] edge_weight;
   } req_type;

   typedef struct packed {
      logic [NODE_W-1:0]        node_index;
      logic signed [DIST_W-1:0] distance;
      logic [1:0]               status;
      logic                     last;
   } rsp_type;
endpackage
`default_nettype wire

### rtl/core/spnc_ram.sv
// generic ram, one write port and one registered read port
`default_nettype none
module spnc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                                  clock,
   input  wire logic                                  wr_en,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                      wr_data,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                           rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

### rtl/core/shortest_path_negative_cycle.sv
// top level of the single source shortest path block with negative cycle detection
`default_nettype none
// Edge loads and clears are taken while idle and may come back to back; busy stays low.
// A run holds busy high while it walks the edge memory: each edge goes at most through
// an edge read, a tail distance read, a head distance read and a compare and write back,
// since both distances come from one single read port memory. A run makes relaxation,
// test and spreading passes over the edges. The results of a run then come one per
// node, each for one cycle on rsp_valid; the receiver cannot stall.
module shortest_path_negative_cycle #(
   parameter int MAX_NODES = 64,
   parameter int MAX_EDGES = 1024
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output logic                   busy,
   input  wire spnc_pkg::req_type req_data,
   output logic                   rsp_valid,
   output spnc_pkg::rsp_type      rsp_data,
   input  wire logic              psel,
   input  wire logic              penable,
   input  wire logic              pwrite,
   input  wire logic [2:0]        paddr,
   input  wire logic [31:0]       pwdata,
   output logic [31:0]            prdata,
   output logic                   pready
);
   import spnc_pkg::*;

   localparam int NI_W  = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
   localparam int EA_W  = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
   localparam int TOT_W = $clog2(MAX_EDGES + 1);
   localparam logic signed [SUM_W-1:0] DIST_HI = SUM_W'((64'sd1 <<< (DIST_W - 1)) - 1);
   localparam logic signed [SUM_W-1:0] DIST_LO = -DIST_HI - SUM_W'(1);

   typedef enum logic [8:0] {
      S_IDLE    = 9'b000000001,
      S_INIT    = 9'b000000010,
      S_EREAD   = 9'b000000100,
      S_EDGE    = 9'b000001000,
      S_DU      = 9'b000010000,
      S_DV      = 9'b000100000,
      S_PASSEND = 9'b001000000,
      S_ORD     = 9'b010000000,
      S_OEMIT   = 9'b100000000
   } state_type;

   typedef enum logic [1:0] {
      PH_RELAX  = 2'd0,
      PH_DETECT = 2'd1,
      PH_SPREAD = 2'd2
   } phase_type;

   state_type                state_ff, state_in;
   phase_type                phase_ff, phase_in;
   logic [COUNT_W-1:0]       node_count_ff, node_count_in;
   logic [NODE_W-1:0]        source_ff, source_in;
   logic [TOT_W-1:0]         total_ff, total_in;
   logic [TOT_W-1:0]         edge_ff, edge_in;
   logic [COUNT_W-1:0]       pass_ff, pass_in;
   logic [NODE_W-1:0]        node_ff, node_in;
   logic                     hit_ff, hit_in;
   logic [MAX_NODES-1:0]     reached_ff, reached_in;
   logic [MAX_NODES-1:0]     marks_ff, marks_in;
   logic [NODE_W-1:0]        tail_ff, tail_in;
   logic [NODE_W-1:0]        head_ff, head_in;
   logic signed [WEIGHT_W-1:0] weight_ff, weight_in;
   logic signed [DIST_W-1:0] du_ff, du_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   rsp_type                  rsp_ff, rsp_in;

   logic                     edge_wr;
   logic [EDGE_W-1:0]        edge_q;
   logic [EA_W-1:0]          edge_rd_addr;
   logic                     dist_wr;
   logic [NI_W-1:0]          dist_wr_addr, dist_rd_addr;
   logic signed [DIST_W-1:0] dist_wr_data, dist_q;
   logic signed [DIST_W-1:0] dv;

   logic [COUNT_W-1:0]       n_use;
   logic                     accept;
   logic signed [SUM_W-1:0]  sum;
   logic signed [DIST_W-1:0] cand;
   logic [NODE_W-1:0]        q_tail, q_head;
   logic                     q_in_range;
   logic                     last_edge;

   spnc_ram #(.WIDTH(EDGE_W), .DEPTH(MAX_EDGES)) u_edge_ram (
      .clock   (clock),
      .wr_en   (edge_wr),
      .wr_addr (total_ff[EA_W-1:0]),
      .wr_data ({req_data.edge_from, req_data.edge_to, req_data.edge_weight}),
      .rd_addr (edge_rd_addr),
      .rd_data (edge_q)
   );

   spnc_ram #(.WIDTH(DIST_W), .DEPTH(MAX_NODES)) u_dist_ram (
      .clock   (clock),
      .wr_en   (dist_wr),
      .wr_addr (dist_wr_addr),
      .wr_data (dist_wr_data),
      .rd_addr (dist_rd_addr),
      .rd_data (dist_q)
   );

   assign pready    = 1'b1;
   assign busy      = (state_ff != S_IDLE);
   assign accept    = start && !busy;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign prdata    = paddr[2] ? {26'd0, source_ff} : {25'd0, node_count_ff};

   always_comb begin
      if (node_count_ff == '0) begin
         n_use = COUNT_W'(1);
      end else if (node_count_ff > COUNT_W'(MAX_NODES)) begin
         n_use = COUNT_W'(MAX_NODES);
      end else begin
         n_use = node_count_ff;
      end
   end

   assign q_tail     = edge_q[EDGE_W-1 -: NODE_W];
   assign q_head     = edge_q[WEIGHT_W +: NODE_W];
   assign q_in_range = (COUNT_W'(q_tail) < n_use) && (COUNT_W'(q_head) < n_use);
   assign last_edge  = (edge_ff + TOT_W'(1)) >= total_ff;

   // an unreached head counts as distance zero
   assign dv = reached_ff[head_ff[NI_W-1:0]] ? dist_q : '0;

   always_comb begin
      sum = SUM_W'(du_ff) + SUM_W'(weight_ff);
      if (sum > DIST_HI) begin
         cand = DIST_HI[DIST_W-1:0];
      end else if (sum < DIST_LO) begin
         cand = DIST_LO[DIST_W-1:0];
      end else begin
         cand = sum[DIST_W-1:0];
      end
   end

   always_comb begin
      state_in      = state_ff;
      phase_in      = phase_ff;
      node_count_in = node_count_ff;
      source_in     = source_ff;
      total_in      = total_ff;
      edge_in       = edge_ff;
      pass_in       = pass_ff;
      node_in       = node_ff;
      hit_in        = hit_ff;
      reached_in    = reached_ff;
      marks_in      = marks_ff;
      tail_in       = tail_ff;
      head_in       = head_ff;
      weight_in     = weight_ff;
      du_in         = du_ff;
      rsp_valid_in  = 1'b0;
      rsp_in        = rsp_ff;
      edge_wr       = 1'b0;
      edge_rd_addr  = edge_ff[EA_W-1:0];
      dist_wr       = 1'b0;
      dist_wr_addr  = source_ff[NI_W-1:0];
      dist_wr_data  = '0;
      dist_rd_addr  = tail_ff[NI_W-1:0];

      if (psel && penable && pwrite) begin
         if (paddr[2]) begin
            source_in = pwdata[NODE_W-1:0];
         end else begin
            node_count_in = pwdata[COUNT_W-1:0];
         end
      end

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               case (req_data.command)
                  CMD_LOAD: begin
                     if (total_ff >= TOT_W'(MAX_EDGES)) begin
                        rsp_valid_in = 1'b1;
                        rsp_in       = '{node_index: '0, distance: '0,
                                         status: ST_OVERFLOW, last: 1'b1};
                     end else begin
                        edge_wr  = 1'b1;
                        total_in = total_ff + TOT_W'(1);
                     end
                  end
                  CMD_RUN:   state_in = S_INIT;
                  CMD_CLEAR: total_in = '0;
                  default: ;
               endcase
            end
         end
         S_INIT: begin
            reached_in = '0;
            marks_in   = '0;
            hit_in     = 1'b0;
            pass_in    = '0;
            edge_in    = '0;
            node_in    = '0;
            phase_in   = PH_RELAX;
            if (COUNT_W'(source_ff) < n_use) begin
               reached_in[source_ff[NI_W-1:0]] = 1'b1;
               dist_wr = 1'b1;
            end
            if (total_ff == '0 || n_use == COUNT_W'(1)) begin
               state_in = S_ORD;
            end else begin
               state_in = S_EREAD;
            end
         end
         S_EREAD: state_in = S_EDGE;
         S_EDGE: begin
            tail_in      = q_tail;
            head_in      = q_head;
            weight_in    = edge_q[WEIGHT_W-1:0];
            dist_rd_addr = q_tail[NI_W-1:0];
            if (!q_in_range) begin
               state_in = last_edge ? S_PASSEND : S_EREAD;
               edge_in  = edge_ff + TOT_W'(1);
            end else if (phase_ff == PH_SPREAD) begin
               if (marks_ff[q_tail[NI_W-1:0]] && !marks_ff[q_head[NI_W-1:0]]) begin
                  marks_in[q_head[NI_W-1:0]] = 1'b1;
                  hit_in = 1'b1;
               end
               state_in = last_edge ? S_PASSEND : S_EREAD;
               edge_in  = edge_ff + TOT_W'(1);
            end else if (!reached_ff[q_tail[NI_W-1:0]]) begin
               state_in = last_edge ? S_PASSEND : S_EREAD;
               edge_in  = edge_ff + TOT_W'(1);
            end else begin
               state_in = S_DU;
            end
         end
         S_DU: begin
            du_in        = dist_q;
            dist_rd_addr = head_ff[NI_W-1:0];
            state_in     = S_DV;
         end
         S_DV: begin
            dist_wr_addr = head_ff[NI_W-1:0];
            dist_wr_data = cand;
            if (phase_ff == PH_RELAX) begin
               if (!reached_ff[head_ff[NI_W-1:0]] || cand < dv) begin
                  dist_wr = 1'b1;
                  reached_in[head_ff[NI_W-1:0]] = 1'b1;
                  hit_in = 1'b1;
               end
            end else if (cand < dv) begin
               marks_in[head_ff[NI_W-1:0]] = 1'b1;
            end
            state_in = last_edge ? S_PASSEND : S_EREAD;
            edge_in  = edge_ff + TOT_W'(1);
         end
         S_PASSEND: begin
            edge_in = '0;
            hit_in  = 1'b0;
            case (phase_ff)
               PH_RELAX: begin
                  if (!hit_ff) begin
                     state_in = S_ORD;
                  end else if ((pass_ff + COUNT_W'(2)) < n_use) begin
                     pass_in  = pass_ff + COUNT_W'(1);
                     state_in = S_EREAD;
                  end else begin
                     phase_in = PH_DETECT;
                     state_in = S_EREAD;
                  end
               end
               PH_DETECT: begin
                  phase_in = PH_SPREAD;
                  pass_in  = '0;
                  state_in = S_EREAD;
               end
               default: begin
                  if (!hit_ff || (pass_ff + COUNT_W'(1)) >= n_use) begin
                     state_in = S_ORD;
                  end else begin
                     pass_in  = pass_ff + COUNT_W'(1);
                     state_in = S_EREAD;
                  end
               end
            endcase
         end
         S_ORD: begin
            dist_rd_addr = node_ff[NI_W-1:0];
            state_in     = S_OEMIT;
         end
         S_OEMIT: begin
            rsp_valid_in      = 1'b1;
            rsp_in.node_index = node_ff;
            rsp_in.last       = (COUNT_W'(node_ff) + COUNT_W'(1)) == n_use;
            if (marks_ff[node_ff[NI_W-1:0]]) begin
               rsp_in.distance = '0;
               rsp_in.status   = ST_MINUS_INF;
            end else if (!reached_ff[node_ff[NI_W-1:0]]) begin
               rsp_in.distance = '0;
               rsp_in.status   = ST_UNREACHABLE;
            end else begin
               rsp_in.distance = dist_q;
               rsp_in.status   = ST_FINITE;
            end
            if ((COUNT_W'(node_ff) + COUNT_W'(1)) == n_use) begin
               state_in = S_IDLE;
            end else begin
               node_in  = node_ff + NODE_W'(1);
               state_in = S_ORD;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         phase_ff      <= PH_RELAX;
         node_count_ff <= COUNT_W'(64);
         source_ff     <= '0;
         total_ff      <= '0;
         edge_ff       <= '0;
         pass_ff       <= '0;
         node_ff       <= '0;
         hit_ff        <= 1'b0;
         reached_ff    <= '0;
         marks_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         phase_ff      <= phase_in;
         node_count_ff <= node_count_in;
         source_ff     <= source_in;
         total_ff      <= total_in;
         edge_ff       <= edge_in;
         pass_ff       <= pass_in;
         node_ff       <= node_in;
         hit_ff        <= hit_in;
         reached_ff    <= reached_in;
         marks_ff      <= marks_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      tail_ff   <= tail_in;
      head_ff   <= head_in;
      weight_ff <= weight_in;
      du_ff     <= du_in;
      rsp_ff    <= rsp_in;
   end
endmodule
`default_nettype wire

### sim/spnc_checker.sv
// checker for the shortest path block: mirrors the registers, predicts every result and compares
`default_nettype none
module spnc_checker (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire logic              busy,
   input  wire spnc_pkg::req_type req_data,
   input  wire logic              rsp_valid,
   input  wire spnc_pkg::rsp_type rsp_data,
   input  wire logic              psel,
   input  wire logic              penable,
   input  wire logic              pwrite,
   input  wire logic [2:0]        paddr,
   input  wire logic [31:0]       pwdata,
   input  wire logic              pready,
   output int                     errors,
   output int                     pending
);
   import spnc_pkg::*;

   localparam int EDGE_CAP = 1024;
   localparam int NODE_CAP = 64;
   localparam longint DIST_HI = (longint'(1) <<< (DIST_W - 1)) - 1;
   localparam longint DIST_LO = -DIST_HI - 1;

   logic [COUNT_W-1:0] node_count;
   logic [NODE_W-1:0]  source_node;
   logic [NODE_W-1:0]  tail_mem [EDGE_CAP];
   logic [NODE_W-1:0]  head_mem [EDGE_CAP];
   longint             cost_mem [EDGE_CAP];
   int                 edge_total;
   rsp_type            distance_queue [$];

   assign pending = distance_queue.size();

   function automatic longint clamp_add(longint a, longint b);
      if (b > 0 && a > DIST_HI - b) return DIST_HI;
      if (b < 0 && a < DIST_LO - b) return DIST_LO;
      return a + b;
   endfunction

   function automatic void push_result(int idx, longint dist_val, status_type st, bit fin);
      rsp_type r;
      r.node_index = idx[NODE_W-1:0];
      r.distance   = dist_val[DIST_W-1:0];
      r.status     = st;
      r.last       = fin;
      distance_queue = {distance_queue, r};
   endfunction

   function automatic void predict_distances();
      int     n, u, v, k;
      bit     reach [NODE_CAP];
      bit     mark [NODE_CAP];
      longint path_len [NODE_CAP];
      longint cand;
      bit     changed, grew;
      n = (node_count == 0) ? 1 : (node_count > NODE_CAP) ? NODE_CAP : int'(node_count);
      for (int i = 0; i < NODE_CAP; i++) begin
         reach[i]    = 0;
         mark[i]     = 0;
         path_len[i] = 0;
      end
      if (source_node < n) reach[source_node] = 1;
      changed = 0;
      for (int p = 0; p + 1 < n; p++) begin
         changed = 0;
         for (int e = 0; e < edge_total; e++) begin
            u = tail_mem[e];
            v = head_mem[e];
            if (u >= n || v >= n || !reach[u]) continue;
            cand = clamp_add(path_len[u], cost_mem[e]);
            if (!reach[v] || cand < path_len[v]) begin
               path_len[v] = cand;
               reach[v]    = 1;
               changed     = 1;
            end
         end
         if (!changed) break;
      end
      if (changed) begin
         for (int e = 0; e < edge_total; e++) begin
            u = tail_mem[e];
            v = head_mem[e];
            if (u >= n || v >= n || !reach[u]) continue;
            if (clamp_add(path_len[u], cost_mem[e]) < path_len[v]) mark[v] = 1;
         end
         for (k = 0; k < n; k++) begin
            grew = 0;
            for (int e = 0; e < edge_total; e++) begin
               u = tail_mem[e];
               v = head_mem[e];
               if (u >= n || v >= n) continue;
               if (mark[u] && !mark[v]) begin
                  mark[v] = 1;
                  grew    = 1;
               end
            end
            if (!grew) break;
         end
      end
      for (int i = 0; i < n; i++) begin
         if (mark[i]) push_result(i, 0, ST_MINUS_INF, i + 1 == n);
         else if (!reach[i]) push_result(i, 0, ST_UNREACHABLE, i + 1 == n);
         else push_result(i, path_len[i], ST_FINITE, i + 1 == n);
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         node_count  <= 7'd64;
         source_node <= '0;
         edge_total  = 0;
         errors      <= 0;
         distance_queue.delete();
      end else begin
         if (rsp_valid) begin
            if (distance_queue.size() == 0) begin
               if (errors < 10)
                  $display("unexpected result: node %0d dist %0d status %0d last %0d",
                           rsp_data.node_index, rsp_data.distance, rsp_data.status,
                           rsp_data.last);
               errors <= errors + 1;
            end else begin
               rsp_type want;
               want = distance_queue.pop_front();
               if (want !== rsp_data) begin
                  if (errors < 10)
                     $display({"mismatch: exp node %0d dist %0d status %0d last %0d, ",
                               "got node %0d dist %0d status %0d last %0d"},
                              want.node_index, want.distance, want.status, want.last,
                              rsp_data.node_index, rsp_data.distance, rsp_data.status,
                              rsp_data.last);
                  errors <= errors + 1;
               end
            end
         end
         if (psel && penable && pwrite && pready) begin
            if (paddr == ADDR_NODE_COUNT) node_count <= pwdata[COUNT_W-1:0];
            else if (paddr == ADDR_SOURCE_NODE) source_node <= pwdata[NODE_W-1:0];
         end
         if (start && !busy) begin
            case (command_type'(req_data.command))
               CMD_LOAD: begin
                  if (edge_total >= EDGE_CAP) push_result(0, 0, ST_OVERFLOW, 1);
                  else begin
                     tail_mem[edge_total] = req_data.edge_from;
                     head_mem[edge_total] = req_data.edge_to;
                     cost_mem[edge_total] = longint'(req_data.edge_weight);
                     edge_total++;
                  end
               end
               CMD_CLEAR: edge_total = 0;
               CMD_RUN:   predict_distances();
               default: ;
            endcase
         end
      end
   end
endmodule
`default_nettype wire

### sim/tb_shortest_path_negative_cycle.sv
// testbench top for the shortest path block: stimulus, register setup and verdict
`default_nettype none
module tb_shortest_path_negative_cycle;
   import spnc_pkg::*;

   logic        clock = 0;
   logic        reset = 1;
   logic        start = 0;
   logic        busy;
   req_type     req_data = '0;
   logic        rsp_valid;
   rsp_type     rsp_data;
   logic        psel = 0, penable = 0, pwrite = 0;
   logic [2:0]  paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;
   int          errors, pending;
   int          item_count = 0;
   int          burst_left = 0;
   int          active_nodes = 64;

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   shortest_path_negative_cycle i_dut (
      .clock, .reset, .start, .busy, .req_data, .rsp_valid, .rsp_data,
      .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
   );

   spnc_checker i_checker (
      .clock, .reset, .start, .busy, .req_data, .rsp_valid, .rsp_data,
      .psel, .penable, .pwrite, .paddr, .pwdata, .pready, .errors, .pending
   );

   task automatic issue(command_type cmd, int src, int dst, logic [31:0] w);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            start <= 0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      start    <= 1;
      req_data <= '{command: cmd, edge_from: src[NODE_W-1:0], edge_to: dst[NODE_W-1:0],
                    edge_weight: w};
      forever begin
         @(negedge clock);
         if (!busy) break;
      end
      @(posedge clock);
      item_count++;
   endtask

   task automatic settle();
      start <= 0;
      forever begin
         @(negedge clock);
         if (pending == 0 && !busy) break;
      end
      repeat (20) @(posedge clock);
   endtask

   task automatic csr_write(logic [2:0] addr, logic [31:0] value);
      psel    <= 1;
      penable <= 0;
      pwrite  <= 1;
      paddr   <= addr;
      pwdata  <= value;
      @(posedge clock);
      penable <= 1;
      @(posedge clock);
      psel    <= 0;
      penable <= 0;
      pwrite  <= 0;
      @(posedge clock);
   endtask

   task automatic configure(int nodes, int src);
      settle();
      csr_write(ADDR_NODE_COUNT, nodes);
      csr_write(ADDR_SOURCE_NODE, src);
      active_nodes = (nodes == 0) ? 1 : (nodes > 64) ? 64 : nodes;
   endtask

   function automatic logic [31:0] pick_weight();
      int sel;
      sel = $urandom_range(0, 19);
      if (sel == 0) return $urandom();
      if (sel == 1) return 32'h7fffffff;
      if (sel == 2) return 32'h80000000;
      return $urandom_range(0, 70) - 20;
   endfunction

   function automatic int pick_node();
      if ($urandom_range(0, 15) == 0) return $urandom_range(0, 63);
      return $urandom_range(0, active_nodes - 1);
   endfunction

   initial begin
      #50000000;
      $display("*** FAILED ***");
      $finish;
   end

   initial begin
      int nodes, src, edges;
      repeat (8) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // reset settings, empty store
      issue(CMD_RUN, 0, 0, 0);
      issue(CMD_NONE, 5, 5, 32'hffffffff);
      // negative cycle with an out-of-range edge
      configure(6, 0);
      issue(CMD_LOAD, 0, 1, 1);
      issue(CMD_LOAD, 1, 2, -3);
      issue(CMD_LOAD, 2, 1, 1);
      issue(CMD_LOAD, 2, 3, 5);
      issue(CMD_LOAD, 3, 63, 7);
      issue(CMD_LOAD, 0, 5, 32'h7fffffff);
      issue(CMD_LOAD, 5, 4, 32'h7fffffff);
      issue(CMD_RUN, 0, 0, 0);
      // source out of range
      configure(4, 63);
      issue(CMD_RUN, 0, 0, 0);
      // extreme negative weights, single node, oversized count
      configure(0, 0);
      issue(CMD_RUN, 0, 0, 0);
      configure(127, 5);
      issue(CMD_CLEAR, 0, 0, 0);
      issue(CMD_LOAD, 5, 6, 32'h80000000);
      issue(CMD_LOAD, 6, 62, 32'h80000000);
      issue(CMD_RUN, 0, 0, 0);
      issue(CMD_CLEAR, 0, 0, 0);

      while (item_count < 310) begin
         if ($urandom_range(0, 9) == 0) nodes = $urandom_range(0, 1) ? 64 : 1;
         else nodes = $urandom_range(2, 12);
         src = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 63)
                                           : $urandom_range(0, (nodes > 0 ? nodes : 1) - 1);
         configure(nodes, src);
         issue(CMD_CLEAR, 0, 0, 0);
         edges = $urandom_range(0, 16);
         for (int e = 0; e < edges; e++) begin
            if ($urandom_range(0, 19) == 0) issue(CMD_NONE, $urandom(), $urandom(), $urandom());
            issue(CMD_LOAD, pick_node(), pick_node(), pick_weight());
         end
         issue(CMD_RUN, 0, 0, 0);
         if ($urandom_range(0, 2) == 0) begin
            issue(CMD_LOAD, pick_node(), pick_node(), pick_weight());
            issue(CMD_RUN, 0, 0, 0);
         end
      end

      settle();
      if (errors == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end
endmodule
`default_nettype wire
